// File: hdl/grs_pkg.sv
// Shared types, constants and the binomial tap function for the 2x reduce block.
`default_nettype none

package grs_pkg;

  // Configuration registers, by index (address bit 2)
  localparam int CFG_W = 13;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 13'd64;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Kernel length and the number of line slots kept for vertical taps
  localparam int NTAPS  = 5;
  localparam int NSLOTS = 4;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Widths of the generic binomial sum (covers pixels up to 16 bits)
  localparam int BINOM_IN_W  = 20;
  localparam int BINOM_OUT_W = 24;

  // Source of one vertical tap: the current row's blur or a stored line slot
  typedef struct packed {
    logic       cur;
    logic [1:0] slot;
  } vsel_t;

  // Control part of one job handed from front to back
  typedef struct packed {
    logic                    emit;
    logic                    row_end;
    logic                    frame_end;
    logic [1:0]              wslot;
    vsel_t [NTAPS-1:0]       sel;
  } job_ctl_t;

  // a0 + 4*a1 + 6*a2 + 4*a3 + a4, by shifts and adds
  function automatic logic [BINOM_OUT_W-1:0] binom5(
    input logic [BINOM_IN_W-1:0] a0,
    input logic [BINOM_IN_W-1:0] a1,
    input logic [BINOM_IN_W-1:0] a2,
    input logic [BINOM_IN_W-1:0] a3,
    input logic [BINOM_IN_W-1:0] a4
  );
    logic [BINOM_OUT_W-1:0] e0, e1, e2, e3, e4;
    e0 = BINOM_OUT_W'(a0);
    e1 = BINOM_OUT_W'(a1);
    e2 = BINOM_OUT_W'(a2);
    e3 = BINOM_OUT_W'(a3);
    e4 = BINOM_OUT_W'(a4);
    return e0 + (e1 << 2) + (e2 << 2) + (e2 << 1) + (e3 << 2) + e4;
  endfunction

endpackage

`default_nettype wire

// File: hdl/grs_front.sv
// Front end: pixel counters, 5-pixel window, horizontal blur and job building.
`default_nettype none

module grs_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               restart,
  input  wire logic [grs_pkg::CFG_W-1:0]          frame_width,
  input  wire logic [grs_pkg::CFG_W-1:0]          frame_height,
  input  wire logic                               pixel_valid,
  input  wire logic [PIXEL_BITS-1:0]              pixel,
  output      logic                               pixel_stall,
  input  wire logic                               q_full,
  output      logic                               push,
  output      grs_pkg::job_ctl_t                  job_ctl,
  output      logic [PIXEL_BITS+3:0]              job_hb,
  output      logic [$clog2(MAX_WIDTH/2)-1:0]     job_co
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = $clog2(MAX_WIDTH / 2);
  localparam int HBW = PIXEL_BITS + 4;
  localparam int BI  = grs_pkg::BINOM_IN_W;

  logic [XW-1:0]         column_count;
  logic [YW-1:0]         row_count;
  logic [PIXEL_BITS-1:0] win [grs_pkg::NTAPS];
  logic [PIXEL_BITS-1:0] win_next [grs_pkg::NTAPS];

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          accept;
  logic          x_last, y_last;
  logic          tx_even, tx_last, tx_trig;
  logic          ty_even, ty_last, ty_trig;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [grs_pkg::BINOM_OUT_W-1:0] hb_wide;
  grs_pkg::vsel_t [grs_pkg::NTAPS-1:0] sel;

  // Clamp the configured size to [2, MAX]
  always_comb begin
    if (frame_width < grs_pkg::CFG_W'(2)) begin
      w_eff = WW'(2);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height < grs_pkg::CFG_W'(2)) begin
      h_eff = HW'(2);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
  end

  assign pixel_stall = q_full;
  assign accept      = pixel_valid && !q_full;

  // Window update: the first pixel of a row fills all taps (left border)
  always_comb begin
    for (int k = 0; k < grs_pkg::NTAPS; k++) begin
      if (column_count == '0) begin
        win_next[k] = pixel;
      end else if (k == grs_pkg::NTAPS - 1) begin
        win_next[k] = pixel;
      end else begin
        win_next[k] = win[k+1];
      end
    end
  end

  // Column and row triggers; a center is complete at even positions of two or more
  // or at the last position of an even size
  assign x_last  = (WW'(column_count) == w_eff - WW'(1));
  assign y_last  = (HW'(row_count) == h_eff - HW'(1));
  assign tx_even = !column_count[0] && (column_count >= XW'(2));
  assign tx_last = x_last && !w_eff[0];
  assign tx_trig = tx_even || tx_last;
  assign ty_even = !row_count[0] && (row_count >= YW'(2));
  assign ty_last = y_last && !h_eff[0];
  assign ty_trig = ty_even || ty_last;
  assign cx      = tx_even ? column_count - XW'(2) : column_count - XW'(1);
  assign cy      = ty_even ? row_count - YW'(2) : row_count - YW'(1);

  // Horizontal blur; at the right border the last pixel repeats
  always_comb begin
    if (tx_even) begin
      hb_wide = grs_pkg::binom5(BI'(win_next[0]), BI'(win_next[1]), BI'(win_next[2]),
                                BI'(win_next[3]), BI'(win_next[4]));
    end else begin
      hb_wide = grs_pkg::binom5(BI'(win_next[1]), BI'(win_next[2]), BI'(win_next[3]),
                                BI'(win_next[4]), BI'(win_next[4]));
    end
  end

  // Vertical tap sources: rows clamped to [0, current row]
  always_comb begin
    logic signed [YW+1:0] rs;
    logic [YW-1:0]        rc;
    for (int k = 0; k < grs_pkg::NTAPS; k++) begin
      rs = $signed({2'b00, cy}) + $signed((YW+2)'(k)) - $signed((YW+2)'(2));
      if (rs[YW+1]) begin
        rc = '0;
      end else if (rs >= $signed({2'b00, row_count})) begin
        rc = row_count;
      end else begin
        rc = YW'(rs);
      end
      sel[k].cur  = (rc == row_count);
      sel[k].slot = rc[1:0];
    end
  end

  // Job to the back end: every trigger column writes the line store
  assign push              = accept && tx_trig;
  assign job_hb            = HBW'(hb_wide);
  assign job_co            = AW'(cx >> 1);
  assign job_ctl.emit      = ty_trig;
  assign job_ctl.row_end   = x_last;
  assign job_ctl.frame_end = x_last && y_last;
  assign job_ctl.wslot     = row_count[1:0];
  assign job_ctl.sel       = sel;

  // Advance the raster position; a configuration write restarts the frame
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (x_last) begin
        column_count <= '0;
        row_count    <= y_last ? '0 : row_count + YW'(1);
      end else begin
        column_count <= column_count + XW'(1);
      end
    end
  end

  // Hold the window between transfers
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < grs_pkg::NTAPS; k++) begin
        win[k] <= win_next[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/grs_queue.sv
// Short job queue that decouples the front end from the back end.
`default_nettype none

module grs_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  output      logic          full,
  input  wire logic          pop,
  output      logic [DW-1:0] pop_data,
  output      logic          empty
);

  localparam int DEPTH = grs_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DW-1:0] entry [DEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entry[head];

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + PW'(1);
      end
      if (pop) begin
        head <= head + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      entry[tail] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/grs_back.sv
// Back end: line store slots, vertical blur and the result register.
`default_nettype none

module grs_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               q_empty,
  output      logic                               pop,
  input  wire grs_pkg::job_ctl_t                  job_ctl,
  input  wire logic [PIXEL_BITS+3:0]              job_hb,
  input  wire logic [$clog2(MAX_WIDTH/2)-1:0]     job_co,
  output      logic                               result_valid,
  input  wire logic                               result_stall,
  output      logic [PIXEL_BITS+7:0]              value,
  output      logic                               row_end,
  output      logic                               frame_end
);

  localparam int HALF_W = MAX_WIDTH / 2;
  localparam int HBW    = PIXEL_BITS + 4;
  localparam int VW     = PIXEL_BITS + 8;
  localparam int BI     = grs_pkg::BINOM_IN_W;

  logic [HBW-1:0]     rd [grs_pkg::NSLOTS];
  logic [HBW-1:0]     hv [grs_pkg::NTAPS];
  logic               s1_v;
  grs_pkg::job_ctl_t  s1_ctl;
  logic [HBW-1:0]     s1_hb;
  logic               out_load;
  logic               s1_free;
  logic [grs_pkg::BINOM_OUT_W-1:0] v_wide;

  assign out_load = s1_v && (!result_valid || !result_stall);
  assign s1_free  = !s1_v || out_load;
  assign pop      = !q_empty && s1_free;

  // One line slot per row modulo four; read all slots, write the current one
  for (genvar g = 0; g < grs_pkg::NSLOTS; g++) begin : g_slot
    logic [HBW-1:0] line_mem [HALF_W];
    logic [HBW-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (pop) begin
        rd_q <= line_mem[job_co];
        if (job_ctl.wslot == 2'(g)) begin
          line_mem[job_co] <= job_hb;
        end
      end
    end

    assign rd[g] = rd_q;
  end

  // Stage 1: hold the job while its line data is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (pop) begin
      s1_v <= job_ctl.emit;
    end else if (out_load) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ctl <= job_ctl;
      s1_hb  <= job_hb;
    end
  end

  // Vertical blur over the selected rows
  always_comb begin
    for (int k = 0; k < grs_pkg::NTAPS; k++) begin
      hv[k] = s1_ctl.sel[k].cur ? s1_hb : rd[s1_ctl.sel[k].slot];
    end
    v_wide = grs_pkg::binom5(BI'(hv[0]), BI'(hv[1]), BI'(hv[2]), BI'(hv[3]), BI'(hv[4]));
  end

  // Result register: load when free or when the current result transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value     <= VW'(v_wide);
      row_end   <= s1_ctl.row_end;
      frame_end <= s1_ctl.frame_end;
    end
  end

endmodule

`default_nettype wire

// File: hdl/gaussian_reduce_2x_stream.sv
// Top level: 2x Gaussian reduce with 5-tap binomial blur, APB config and checks.
//
//   channel   direction  handshake                  payload
//   pixel     in         pixel_valid/pixel_stall    pixel
//   result    out        result_valid/result_stall  value, row_end, frame_end
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One pixel is taken per clock; the pixel path stalls only when the 4-entry
// job queue is full. The job of the pixel that completes a result's taps
// enters the queue with that pixel's transfer; the line store is then read
// into stage 1 and the result register loads after it, and a busy back end
// or result_stall can hold the job on the way.
// The line store needs no clearing pass: every slot read was written earlier
// in the same frame. Reset is synchronous and sets both sizes to 64.
// A configuration write restarts the frame at pixel (0,0).
`default_nettype none

module gaussian_reduce_2x_stream #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pixel_valid,
  output      logic                  pixel_stall,
  input  wire logic [PIXEL_BITS-1:0] pixel,
  output      logic                  result_valid,
  input  wire logic                  result_stall,
  output      logic [PIXEL_BITS+7:0] value,
  output      logic                  row_end,
  output      logic                  frame_end,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready
);

  localparam int AW  = $clog2(MAX_WIDTH / 2);
  localparam int HBW = PIXEL_BITS + 4;
  localparam int CTW = $bits(grs_pkg::job_ctl_t);
  localparam int QW  = CTW + HBW + AW;

  logic [grs_pkg::CFG_W-1:0] frame_width;
  logic [grs_pkg::CFG_W-1:0] frame_height;
  logic                      cfg_wr;

  logic              q_push, q_pop, q_full, q_empty;
  grs_pkg::job_ctl_t f_ctl, b_ctl;
  logic [HBW-1:0]    f_hb, b_hb;
  logic [AW-1:0]     f_co, b_co;
  logic [QW-1:0]     q_out;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= grs_pkg::CFG_SIZE_RESET;
      frame_height <= grs_pkg::CFG_SIZE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == grs_pkg::REG_FRAME_WIDTH) begin
        frame_width <= pwdata[grs_pkg::CFG_W-1:0];
      end else begin
        frame_height <= pwdata[grs_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == grs_pkg::REG_FRAME_HEIGHT) begin
      prdata = 32'(frame_height);
    end else begin
      prdata = 32'(frame_width);
    end
  end

  grs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_wr),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pixel_valid  (pixel_valid),
    .pixel        (pixel),
    .pixel_stall  (pixel_stall),
    .q_full       (q_full),
    .push         (q_push),
    .job_ctl      (f_ctl),
    .job_hb       (f_hb),
    .job_co       (f_co)
  );

  grs_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_ctl, f_hb, f_co}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign b_ctl = q_out[QW-1 -: CTW];
  assign b_hb  = q_out[AW +: HBW];
  assign b_co  = q_out[AW-1:0];

  grs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .pop          (q_pop),
    .job_ctl      (b_ctl),
    .job_hb       (b_hb),
    .job_co       (b_co),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .row_end      (row_end),
    .frame_end    (frame_end)
  );

  // No push into a full queue, no pop from an empty one
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("job pushed into full queue");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop)
    else $error("job popped from empty queue");

  // The last result of a frame closes its row
  a_frame_row : assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_end) |-> row_end)
    else $error("frame end without row end");

  // A job popped while the queue held one entry and nothing was pushed empties it
  a_drain : assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_push && !q_full && !q_empty && $past(q_empty) && !$past(rst))
      |=> q_empty)
    else $error("queue did not drain");

endmodule

`default_nettype wire
